[design/gtg_pkg.sv]
package gtg_pkg;

    // Register map of the configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_RADIUS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT   = 8'd3;

    // Register reset values: 0.20 m, 0.25 m/s, gain 1.5, 1.0 rad/s
    localparam logic [30:0] GOAL_RADIUS_RST  = 31'd13107;
    localparam logic [14:0] CRUISE_SPEED_RST = 15'd1024;
    localparam logic [14:0] HEADING_GAIN_RST = 15'd6144;
    localparam logic [14:0] TURN_LIMIT_RST   = 15'd4096;

    // Request kinds
    localparam logic REQ_GOAL = 1'b0;
    localparam logic REQ_POSE = 1'b1;

    // CORDIC
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int CORDIC_MAX_STEPS      = 24;
    localparam int ITER_W                = $clog2(CORDIC_MAX_STEPS);
    localparam int CORDIC_W              = 36;

    // atan(2^-i) with a full circle of 2^32
    localparam logic [31:0] CORDIC_ANGLES [CORDIC_MAX_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680094,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    localparam logic [31:0] Z_QUARTER       = 32'h4000_0000;
    localparam logic [31:0] Z_THREE_QUARTER = 32'hC000_0000;

    // pi in Q2.29
    localparam logic [30:0] PI_Q29 = 31'd1686629713;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int RATE_SHIFT = 44;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQ_R,
        ST_COMPARE,
        ST_ROTATE,
        ST_ERROR,
        ST_GAIN,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIFF,
        OP_SQ_DX,
        OP_SQ_DY,
        OP_SQ_R,
        OP_COMPARE,
        OP_ROTATE,
        OP_ERROR,
        OP_GAIN,
        OP_SCALE
    } t_op;

    typedef struct packed {
        logic              req_type;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic              path_empty;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] robot_heading;
    } t_item;

    typedef struct packed {
        logic [14:0]        linear_speed;
        logic signed [15:0] angular_rate;
        logic               goal_reached;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_req;

    typedef struct packed {
        logic              accept;
        t_op               op;
        logic [ITER_W-1:0] iter;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic gives_result;
        logic reached;
        logic out_free;
    } t_status;

endpackage

[design/gtg_if.sv]
interface gtg_in_if;
    import gtg_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic               path_empty;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_heading;

    modport source (
        output valid, req_type, goal_x, goal_y, path_empty, robot_x, robot_y, robot_heading,
        input  ready
    );
    modport sink (
        input  valid, req_type, goal_x, goal_y, path_empty, robot_x, robot_y, robot_heading,
        output ready
    );
endinterface

interface gtg_out_if;
    import gtg_pkg::*;

    logic               valid;
    logic               ready;
    logic [14:0]        linear_speed;
    logic signed [15:0] angular_rate;
    logic               goal_reached;

    modport source (
        output valid, linear_speed, angular_rate, goal_reached,
        input  ready
    );
    modport sink (
        input  valid, linear_speed, angular_rate, goal_reached,
        output ready
    );
endinterface

interface gtg_cfg_if;
    import gtg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[design/gtg_ctrl.sv]
module gtg_ctrl #(
    parameter int CORDIC_ITERATIONS = gtg_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gtg_pkg::t_status i_status,
    output gtg_pkg::t_cmd    o_cmd
);
    import gtg_pkg::*;

    localparam logic [ITER_W-1:0] LastIter = ITER_W'(CORDIC_ITERATIONS - 1);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_iter         = r_iter;
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.op       = OP_NONE;
        o_cmd.iter     = r_iter;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.gives_result) begin
                        n_state = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = ST_SQ_DX;
            end
            ST_SQ_DX: begin
                o_cmd.op = OP_SQ_DX;
                n_state  = ST_SQ_DY;
            end
            ST_SQ_DY: begin
                o_cmd.op = OP_SQ_DY;
                n_state  = ST_SQ_R;
            end
            ST_SQ_R: begin
                o_cmd.op = OP_SQ_R;
                n_state  = ST_COMPARE;
            end
            ST_COMPARE: begin
                o_cmd.op = OP_COMPARE;
                n_iter   = '0;
                n_state  = i_status.reached ? ST_DONE : ST_ROTATE;
            end
            ST_ROTATE: begin
                o_cmd.op = OP_ROTATE;
                if (r_iter == LastIter) begin
                    n_state = ST_ERROR;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            ST_ERROR: begin
                o_cmd.op = OP_ERROR;
                n_state  = ST_GAIN;
            end
            ST_GAIN: begin
                o_cmd.op = OP_GAIN;
                n_state  = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/gtg_dp.sv]
module gtg_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gtg_pkg::t_item    i_item,
    input  gtg_pkg::t_cfg_req i_cfg,
    input  gtg_pkg::t_cmd     i_cmd,
    output gtg_pkg::t_status  o_status,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output gtg_pkg::t_result  o_res
);
    import gtg_pkg::*;

    // Configuration
    logic [30:0] r_goal_radius;
    logic [14:0] r_cruise_speed;
    logic [14:0] r_heading_gain;
    logic [14:0] r_turn_limit;

    // Latest goal and pose
    logic signed [31:0] r_target_x, r_target_y;
    logic               r_target_valid;
    logic signed [31:0] r_pose_x, r_pose_y;
    logic signed [15:0] r_pose_heading;
    logic               r_pose_valid;

    // Working registers
    logic signed [MUL_W-1:0]    r_dx, r_dy;
    logic signed [PROD_W-1:0]   r_prod;
    logic [63:0]                r_dx2, r_dy2;
    logic                       r_reached;
    logic                       r_zero;
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic [31:0]                r_z;
    logic signed [15:0]         r_err;

    // Result register
    logic    r_out_valid;
    t_result r_out;

    logic                       tv_next, pv_next;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic [64:0]                dist2;
    logic                       reached_now;
    logic signed [CORDIC_W-1:0] ex, ey, xs, ys;
    logic [31:0]                ang;
    logic [31:0]                brg_sum;
    logic [15:0]                brg;
    logic signed [PROD_W-1:0]   rate_sum;
    logic signed [21:0]         rate_raw, rate_lim, rate_sat;

    always_comb begin
        tv_next = (i_item.req_type == REQ_POSE) ? r_target_valid : !i_item.path_empty;
        pv_next = (i_item.req_type == REQ_POSE) ? 1'b1 : r_pose_valid;
    end

    always_comb begin
        case (i_cmd.op)
            OP_SQ_DX: begin
                mul_a = r_dx;
                mul_b = r_dx;
            end
            OP_SQ_DY: begin
                mul_a = r_dy;
                mul_b = r_dy;
            end
            OP_SQ_R: begin
                mul_a = signed'({2'b00, r_goal_radius});
                mul_b = signed'({2'b00, r_goal_radius});
            end
            OP_GAIN: begin
                mul_a = signed'({18'd0, r_heading_gain});
                mul_b = MUL_W'(r_err);
            end
            OP_SCALE: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = signed'({2'b00, PI_Q29});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // r_prod holds the squared radius while the compare runs
    assign dist2       = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign reached_now = dist2 < {1'b0, r_prod[63:0]};

    assign ex  = CORDIC_W'(r_dx);
    assign ey  = CORDIC_W'(r_dy);
    assign xs  = r_x >>> i_cmd.iter;
    assign ys  = r_y >>> i_cmd.iter;
    assign ang = CORDIC_ANGLES[i_cmd.iter];

    assign brg_sum = r_z + 32'h0000_8000;
    assign brg     = r_zero ? 16'd0 : brg_sum[31:16];

    // Round half up, then clamp to the turn limit
    always_comb begin
        rate_sum = r_prod + (PROD_W'(1) <<< (RATE_SHIFT - 1));
        rate_raw = rate_sum[PROD_W-1:RATE_SHIFT];
        rate_lim = signed'({7'd0, r_turn_limit});
        if (rate_raw > rate_lim) begin
            rate_sat = rate_lim;
        end else if (rate_raw < -rate_lim) begin
            rate_sat = -rate_lim;
        end else begin
            rate_sat = rate_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_radius  <= GOAL_RADIUS_RST;
            r_cruise_speed <= CRUISE_SPEED_RST;
            r_heading_gain <= HEADING_GAIN_RST;
            r_turn_limit   <= TURN_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GOAL_RADIUS:  r_goal_radius  <= i_cfg.data[30:0];
                CFG_CRUISE_SPEED: r_cruise_speed <= i_cfg.data[14:0];
                CFG_HEADING_GAIN: r_heading_gain <= i_cfg.data[14:0];
                CFG_TURN_LIMIT:   r_turn_limit   <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x     <= '0;
            r_target_y     <= '0;
            r_target_valid <= 1'b0;
            r_pose_x       <= '0;
            r_pose_y       <= '0;
            r_pose_heading <= '0;
            r_pose_valid   <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_item.req_type == REQ_GOAL) begin
                if (i_item.path_empty) begin
                    r_target_valid <= 1'b0;
                end else begin
                    r_target_x     <= i_item.goal_x;
                    r_target_y     <= i_item.goal_y;
                    r_target_valid <= 1'b1;
                end
            end else begin
                r_pose_x       <= i_item.robot_x;
                r_pose_y       <= i_item.robot_y;
                r_pose_heading <= i_item.robot_heading;
                r_pose_valid   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op inside {OP_SQ_DX, OP_SQ_DY, OP_SQ_R, OP_GAIN, OP_SCALE}) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.op)
            OP_DIFF: begin
                r_dx <= MUL_W'(r_target_x) - MUL_W'(r_pose_x);
                r_dy <= MUL_W'(r_target_y) - MUL_W'(r_pose_y);
            end
            OP_SQ_DY: begin
                r_dx2 <= r_prod[63:0];
            end
            OP_SQ_R: begin
                r_dy2 <= r_prod[63:0];
            end
            OP_COMPARE: begin
                r_reached <= reached_now;
                r_zero    <= (r_dx == '0) && (r_dy == '0);
                if (ex[CORDIC_W-1]) begin
                    if (!ey[CORDIC_W-1]) begin
                        r_x <= ey;
                        r_y <= -ex;
                        r_z <= Z_QUARTER;
                    end else begin
                        r_x <= -ey;
                        r_y <= ex;
                        r_z <= Z_THREE_QUARTER;
                    end
                end else begin
                    r_x <= ex;
                    r_y <= ey;
                    r_z <= '0;
                end
            end
            OP_ROTATE: begin
                if (!r_y[CORDIC_W-1]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + ang;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - ang;
                end
            end
            OP_ERROR: begin
                r_err <= signed'(brg - r_pose_heading);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_reached) begin
                r_out.linear_speed <= '0;
                r_out.angular_rate <= '0;
                r_out.goal_reached <= 1'b1;
            end else begin
                r_out.linear_speed <= r_cruise_speed;
                r_out.angular_rate <= rate_sat[15:0];
                r_out.goal_reached <= 1'b0;
            end
        end
    end

    assign o_status.gives_result = tv_next && pv_next;
    assign o_status.reached      = reached_now;
    assign o_status.out_free     = !r_out_valid || i_res_ready;
    assign o_res_valid           = r_out_valid;
    assign o_res                 = r_out;

endmodule

[design/go_to_goal_heading_controller.sv]
// Go-to-goal heading controller. Two kinds of request arrive on i_item: a goal
// update (req_type 0) carrying the final path point or, with path_empty set,
// a mark that no goal exists; and a pose update (req_type 1) carrying the robot
// x, y (Q16.16 metres) and heading (binary angle units, 32768 = pi). Each request
// that leaves both a goal and a pose held yields one drive command on o_res;
// any other request only updates the held state. Inside the goal radius
// (squared distances compared exactly) the command is zero speed with
// goal_reached set; otherwise it is the cruise speed and a turn rate of
// gain * wrapped bearing error, clamped to +-turn_limit, with the bearing from
// an iterative CORDIC atan2. Requests are taken one at a time. A command that
// ends inside the radius skips the CORDIC loop; a steering command's time is
// set by the CORDIC loop, which retires one micro-rotation a cycle, and by the
// single shared 33 x 33 multiplier, which is used in turn for the three
// squares, the gain product and the pi scaling. A finished command sits in an
// output register, so a stalled consumer holds back the next request only
// once that register is still full at the end of its work.
// The configuration port (index 0 goal_radius, 1 cruise_speed, 2 heading_gain,
// 3 turn_limit) is always ready; write it only while the block is idle.
module go_to_goal_heading_controller #(
    parameter int CORDIC_ITERATIONS = gtg_pkg::CORDIC_ITERATIONS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    gtg_in_if.sink     i_item,
    gtg_out_if.source  o_res,
    gtg_cfg_if.sink    i_cfg
);
    import gtg_pkg::*;

    t_item    item;
    t_cfg_req cfg_req;
    t_cmd     cmd;
    t_status  status;
    t_result  res;
    logic     res_valid;

    // Gather the request payload into one word for the datapath
    assign item.req_type      = i_item.req_type;
    assign item.goal_x        = i_item.goal_x;
    assign item.goal_y        = i_item.goal_y;
    assign item.path_empty    = i_item.path_empty;
    assign item.robot_x       = i_item.robot_x;
    assign item.robot_y       = i_item.robot_y;
    assign item.robot_heading = i_item.robot_heading;

    // Configuration writes go straight into the registers, so never stall them
    assign i_cfg.ready    = 1'b1;
    assign cfg_req.valid  = i_cfg.valid;
    assign cfg_req.index  = i_cfg.index;
    assign cfg_req.data   = i_cfg.data;

    // Sequencer: accepts requests, steps the datapath, loads the result register
    gtg_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Held state, multiplier, CORDIC rotator and result register
    gtg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_cfg       (cfg_req),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (res)
    );

    // Drive the result channel straight from the result register
    assign o_res.valid        = res_valid;
    assign o_res.linear_speed = res.linear_speed;
    assign o_res.angular_rate = res.angular_rate;
    assign o_res.goal_reached = res.goal_reached;

endmodule

[design/gtg_checker.sv]
module gtg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [14:0] i_linear_speed,
    input logic [15:0] i_angular_rate,
    input logic        i_goal_reached
);

    // A stalled command holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_linear_speed)
            && $stable(i_angular_rate) && $stable(i_goal_reached))
        else $error("stalled command changed");

    // Inside the radius both speeds are zero
    a_reached_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_goal_reached |-> i_linear_speed == 15'd0 && i_angular_rate == 16'd0)
        else $error("goal reached with non-zero speed");

    // The clamp never lets the most negative code through
    a_rate_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_angular_rate != 16'h8000)
        else $error("turn rate outside clamp range");

    // A new command only appears while the request side is busy
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> !$past(i_in_ready))
        else $error("command loaded while idle");

endmodule

bind go_to_goal_heading_controller gtg_checker u_gtg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_item.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_linear_speed (o_res.linear_speed),
    .i_angular_rate (o_res.angular_rate),
    .i_goal_reached (o_res.goal_reached)
);
